// ===== rtl/servo_pulse_mode_sweep_generator_top_macros.svh =====
// Assertion macros for the servo pulse generator top level.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef SERVO_PULSE_MODE_SWEEP_GENERATOR_TOP_MACROS_SVH
`define SERVO_PULSE_MODE_SWEEP_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define SPMSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPMSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spmsg_pkg.sv =====
// Shared types and constants for the servo pulse generator.
// No dependencies.
package spmsg_pkg;

	localparam int DivW = 32;
	localparam int CntW = 6;

	localparam logic [2:0] RegMode     = 3'd0;
	localparam logic [2:0] RegMin      = 3'd1;
	localparam logic [2:0] RegMax      = 3'd2;
	localparam logic [2:0] RegReverse  = 3'd3;
	localparam logic [2:0] RegCycleSec = 3'd4;
	localparam logic [2:0] RegStep     = 3'd5;
	localparam logic [2:0] RegDeadband = 3'd6;
	localparam logic [2:0] RegMaxStep  = 3'd7;

	localparam logic [1:0] ModePot    = 2'd0;
	localparam logic [1:0] ModeCenter = 2'd1;
	localparam logic [1:0] ModeSweep  = 2'd2;
	localparam logic [1:0] ModeSpare  = 2'd3;

	localparam logic [9:0]  PotFull  = 10'd1023;
	localparam logic [9:0]  MsPerSec = 10'd1000;

	// reciprocals: x/1023 = (x*R)>>32 for x < 2^22, x/100 = (x*R)>>26 for x < 2^19,
	// x/3 = (x*R)>>14 for x < 2^12
	localparam logic [22:0] Recip1023 = 23'd4198405;
	localparam logic [19:0] Recip100  = 20'd671089;
	localparam logic [12:0] Recip3    = 13'd5462;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] dividend;
		logic [DivW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            busy;
		logic            done;
		logic [DivW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/spmsg_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on spmsg_pkg.
module spmsg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  spmsg_pkg::div_req_t req,
	output spmsg_pkg::div_rsp_t rsp
);

	logic [spmsg_pkg::DivW-1:0] rem_q, quo_q, dvs_q;
	logic [spmsg_pkg::CntW-1:0] cnt_q;
	logic                       busy_q, done_q;
	logic [spmsg_pkg::DivW:0]   trial;
	logic                       fits;

	assign trial = {rem_q, quo_q[spmsg_pkg::DivW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= spmsg_pkg::CntW'(spmsg_pkg::DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == spmsg_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[spmsg_pkg::DivW-1:0] - dvs_q
			              : trial[spmsg_pkg::DivW-1:0];
			quo_q <= {quo_q[spmsg_pkg::DivW-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/servo_pulse_mode_sweep_generator_top.sv =====
// Servo pulse generator top level: registers, sequencer and output stage.
// Depends on spmsg_pkg, spmsg_div and the assertion macro header.
//
// Use: an input request carries kind, now_ms and pot_sample on in_valid/in_stall.
// A restart request (kind 1) resets the sweep and gives no result.
// An update tick gives one result (pulse_us, display_us, cycle_count) on
// out_valid/out_stall. Registers are written on cfg_valid/cfg_ready; the
// user must do so only while idle (not enforced); cfg_ready is always high.
// The sweep interval takes one or two passes of the divider, which only the
// sweep uses; the pot map and the display filter use reciprocal multiplies.
// The display pass either just follows the pulse, holds inside the deadband
// or steps toward the pulse. in_stall stays high while an update is in work;
// the next request can be taken in the cycle after the result is loaded.
// The result sits in an output register; while out_stall holds it, the
// finished request waits before the register and in_stall stays high.
// Reset clears control state and loads register defaults; no clearing pass.
module servo_pulse_mode_sweep_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] now_ms,
	input  logic [9:0]  pot_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] pulse_us,
	output logic [11:0] display_us,
	output logic [31:0] cycle_count
);

	`include "servo_pulse_mode_sweep_generator_top_macros.svh"

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StPotW  = 4'd1;
	localparam logic [3:0] StSwD1  = 4'd2;
	localparam logic [3:0] StSwD2  = 4'd3;
	localparam logic [3:0] StDisp  = 4'd4;
	localparam logic [3:0] StDbW   = 4'd5;
	localparam logic [3:0] StMsW   = 4'd6;
	localparam logic [3:0] StStW   = 4'd7;
	localparam logic [3:0] StFin   = 4'd8;
	localparam logic [3:0] StPotP  = 4'd9;

	logic [1:0]  mode_q;
	logic [11:0] min_q, max_q;
	logic        rev_q;
	logic [5:0]  cyc_q;
	logic [7:0]  step_q;
	logic [6:0]  dbp_q, msp_q;

	logic [11:0] pos_q;
	logic        down_q, top_q;
	logic [31:0] trips_q, last_q;
	logic [11:0] shown_q;
	logic        shown_vld_q;

	logic [3:0]  st_q;
	logic [31:0] now_q;
	logic [9:0]  pot_q;
	logic [11:0] pulse_q;
	logic [12:0] db_q, ms_q;
	logic [21:0] prod_q;
	logic [18:0] pdb_q, pms_q;
	logic [10:0] third_q;

	logic        out_vld_q;
	logic [11:0] out_pulse_q, out_disp_q;
	logic [31:0] out_trips_q;

	spmsg_pkg::div_req_t dreq;
	spmsg_pkg::div_rsp_t drsp;

	spmsg_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic        in_acc, out_free;
	logic [9:0]  pot_v;
	logic        d_neg;
	logic [11:0] d_mag;
	logic [11:0] span;
	logic [31:0] span32, full32;
	logic [31:0] cyc_ms;
	logic [31:0] q;
	logic [31:0] steps, iv, elapsed;
	logic        bypass;
	logic [12:0] diff;
	logic [11:0] absd;
	logic [12:0] smag;
	logic signed [13:0] snext;
	logic signed [14:0] dnext;
	logic [44:0] pot_prod;
	logic [38:0] db_prod, ms_prod;
	logic [24:0] th_prod;
	logic [12:0] db_quo, ms_quo;

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != StIdle);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_vld_q || !out_stall;
	assign q         = drsp.quotient;

	assign pot_v  = rev_q ? (spmsg_pkg::PotFull - pot_q) : pot_q;
	assign d_neg  = max_q < min_q;
	assign d_mag  = d_neg ? (min_q - max_q) : (max_q - min_q);
	assign span   = max_q - min_q;
	assign span32 = {20'd0, max_q} - {20'd0, min_q};
	assign full32 = {span32[30:0], 1'b0};
	assign cyc_ms = {26'd0, cyc_q} * {22'd0, spmsg_pkg::MsPerSec};
	assign steps  = (q == 32'd0) ? 32'd1 : q;
	assign iv     = (q == 32'd0) ? 32'd1 : q;
	assign elapsed = now_q - last_q;
	assign bypass = !shown_vld_q || (max_q <= min_q);
	assign diff   = {1'b0, pulse_q} - {1'b0, shown_q};
	assign absd   = diff[12] ? 12'(-diff) : diff[11:0];
	assign snext  = down_q ? ($signed({2'b00, pos_q}) - $signed({6'd0, step_q}))
	                       : ($signed({2'b00, pos_q}) + $signed({6'd0, step_q}));

	assign pot_prod = {23'd0, prod_q} * {22'd0, spmsg_pkg::Recip1023};
	assign db_prod  = {20'd0, pdb_q} * {19'd0, spmsg_pkg::Recip100};
	assign ms_prod  = {20'd0, pms_q} * {19'd0, spmsg_pkg::Recip100};
	assign th_prod  = {13'd0, absd} * {12'd0, spmsg_pkg::Recip3};
	assign db_quo   = db_prod[38:26];
	assign ms_quo   = ms_prod[38:26];

	always_comb begin
		smag = (third_q == 11'd0) ? 13'd1 : {2'b00, third_q};
		if (smag > ms_q) smag = ms_q;
		dnext = diff[12] ? ($signed({3'b000, shown_q}) - $signed({2'b00, smag}))
		                 : ($signed({3'b000, shown_q}) + $signed({2'b00, smag}));
	end

	always_comb begin
		dreq = '0;
		unique case (st_q)
			StIdle: begin
				if (in_valid && !kind && (mode_q != spmsg_pkg::ModePot)
				    && (mode_q != spmsg_pkg::ModeCenter)) begin
					dreq.start = 1'b1;
					if (step_q == 8'd0) begin
						dreq.dividend = cyc_ms;
						dreq.divisor  = 32'd1;
					end else begin
						dreq.dividend = full32;
						dreq.divisor  = {24'd0, step_q};
					end
				end
			end
			StSwD1: begin
				dreq.start    = drsp.done;
				dreq.dividend = cyc_ms;
				dreq.divisor  = steps;
			end
			default: dreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0; min_q <= 12'd1000; max_q <= 12'd2000; rev_q <= 1'b0;
			cyc_q <= 6'd4; step_q <= 8'd10; dbp_q <= 7'd1; msp_q <= 7'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spmsg_pkg::RegMode:     mode_q <= cfg_data[1:0];
				spmsg_pkg::RegMin:      min_q  <= cfg_data;
				spmsg_pkg::RegMax:      max_q  <= cfg_data;
				spmsg_pkg::RegReverse:  rev_q  <= cfg_data[0];
				spmsg_pkg::RegCycleSec: cyc_q  <= cfg_data[5:0];
				spmsg_pkg::RegStep:     step_q <= cfg_data[7:0];
				spmsg_pkg::RegDeadband: dbp_q  <= cfg_data[6:0];
				spmsg_pkg::RegMaxStep:  msp_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle;
			pos_q <= '0; down_q <= 1'b0; top_q <= 1'b0;
			trips_q <= '0; last_q <= '0;
			shown_q <= '0; shown_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= ((st_q == StFin) && out_free) || (out_vld_q && out_stall);
			unique case (st_q)
				StIdle: begin
					if (in_acc) begin
						if (kind) begin
							pos_q <= min_q; down_q <= 1'b0; trips_q <= '0;
							top_q <= 1'b0; last_q <= now_ms;
						end else if (mode_q == spmsg_pkg::ModePot) begin
							st_q <= StPotP;
						end else if (mode_q == spmsg_pkg::ModeCenter) begin
							st_q <= StDisp;
						end else begin
							if (pos_q < min_q) begin
								pos_q <= min_q; down_q <= 1'b0; top_q <= 1'b0;
							end else if (pos_q > max_q) begin
								pos_q <= max_q; down_q <= 1'b1; top_q <= 1'b1;
							end
							st_q <= (step_q == 8'd0) ? StSwD2 : StSwD1;
						end
					end
				end
				StPotP: st_q <= StPotW;
				StPotW: st_q <= StDisp;
				StSwD1: if (drsp.done) st_q <= StSwD2;
				StSwD2: begin
					if (drsp.done) begin
						if (elapsed >= iv) begin
							last_q <= now_q;
							if (snext >= $signed({2'b00, max_q})) begin
								pos_q <= max_q; down_q <= 1'b1; top_q <= 1'b1;
							end else if (snext <= $signed({2'b00, min_q})) begin
								pos_q <= min_q; down_q <= 1'b0; top_q <= 1'b0;
								if (top_q && (trips_q != 32'hFFFF_FFFF))
									trips_q <= trips_q + 1'b1;
							end else begin
								pos_q <= snext[11:0];
							end
						end
						st_q <= StDisp;
					end
				end
				StDisp: begin
					if (bypass) begin
						shown_q <= pulse_q; shown_vld_q <= 1'b1; st_q <= StFin;
					end else begin
						st_q <= StDbW;
					end
				end
				StDbW: st_q <= StMsW;
				StMsW: st_q <= ({1'b0, absd} > db_q) ? StStW : StFin;
				StStW: begin
					if (dnext < $signed({3'b000, min_q})) shown_q <= min_q;
					else if (dnext > $signed({3'b000, max_q})) shown_q <= max_q;
					else shown_q <= dnext[11:0];
					st_q <= StFin;
				end
				StFin: begin
					if (out_free) st_q <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q <= now_ms;
			pot_q <= pot_sample;
		end
		if (st_q == StIdle && in_acc && mode_q == spmsg_pkg::ModeCenter)
			pulse_q <= 12'(({1'b0, min_q} + {1'b0, max_q}) >> 1);
		if (st_q == StPotP)
			prod_q <= {12'd0, pot_v} * {10'd0, d_mag};
		if (st_q == StPotW)
			pulse_q <= d_neg ? (min_q - pot_prod[43:32]) : (min_q + pot_prod[43:32]);
		if (st_q == StSwD2 && drsp.done) begin
			if (elapsed >= iv) begin
				if (snext >= $signed({2'b00, max_q})) pulse_q <= max_q;
				else if (snext <= $signed({2'b00, min_q})) pulse_q <= min_q;
				else pulse_q <= snext[11:0];
			end else begin
				pulse_q <= pos_q;
			end
		end
		if (st_q == StDisp && !bypass) begin
			pdb_q <= {7'd0, span} * {12'd0, dbp_q};
			pms_q <= {7'd0, span} * {12'd0, msp_q};
		end
		if (st_q == StDbW) begin
			db_q <= (db_quo == 13'd0) ? 13'd1 : db_quo;
			ms_q <= (ms_quo == 13'd0) ? 13'd1 : ms_quo;
		end
		if (st_q == StMsW) third_q <= th_prod[24:14];
		if (st_q == StFin && out_free) begin
			out_pulse_q <= pulse_q;
			out_disp_q  <= shown_q;
			out_trips_q <= trips_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign pulse_us    = out_pulse_q;
	assign display_us  = out_disp_q;
	assign cycle_count = out_trips_q;

	`SPMSG_ASSERT_NOW(a_div_owner, drsp.busy, (st_q == StSwD1) || (st_q == StSwD2), "divider busy")
	`SPMSG_ASSERT_NOW(a_out_from_fin, $rose(out_vld_q), $past(st_q) == StFin, "result raised without finish")
	`SPMSG_ASSERT_NEXT(a_tick_starts, in_acc && !kind, st_q != StIdle, "update tick did not start work")

endmodule
